// ===== hw/rtl/gtd_pkg.sv =====
package gtd_pkg;

   // widest recurrence delay supported; narrower delays are sign-extended
   localparam int DELAY_W = 48;
   localparam int ENERGY_W = 48;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [31:0] RATIO_RESET = 32'd65536;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TWO_COS = 2'd0,
      REG_COS     = 2'd1,
      REG_SIN     = 2'd2,
      REG_RATIO   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic signed [16:0] two_cos;
      logic signed [15:0] cos_q;
      logic signed [15:0] sin_q;
      logic [31:0]        ratio;
   } cfg_type;

   // one finished block as handed from the front to the back
   typedef struct packed {
      logic signed [DELAY_W-1:0] d1;
      logic signed [DELAY_W-1:0] d2;
      logic [ENERGY_W-1:0]       energy;
   } entry_type;

endpackage

// ===== hw/rtl/gtd_front.sv =====
module gtd_front #(
   parameter int ACC_BITS  = 40,
   parameter int MAX_BLOCK = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  gtd_pkg::cfg_type   cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_sample,
   input  logic               req_last,
   input  logic               q_full,
   output logic               push,
   output gtd_pkg::entry_type push_entry
);
   import gtd_pkg::*;

   localparam int ProdW = ACC_BITS + 17;
   localparam int SumW  = ACC_BITS + 5;
   localparam int CntW  = (MAX_BLOCK > 2) ? $clog2(MAX_BLOCK) : 1;
   localparam logic signed [SumW-1:0] SatHi = $signed({6'b0, {(ACC_BITS-1){1'b1}}});
   localparam logic signed [SumW-1:0] SatLo = $signed({6'b111111, {(ACC_BITS-1){1'b0}}});

   logic signed [ACC_BITS-1:0] d1_ff, d1_in, d2_ff, d2_in, d1_sat;
   logic [ENERGY_W-1:0]        energy_ff, energy_in, energy_sum;
   logic [CntW-1:0]            cnt_ff, cnt_in;
   logic signed [ProdW-1:0]    prod, prod_rnd;
   logic signed [SumW-1:0]     s0;
   logic signed [31:0]         sq;
   logic [ENERGY_W:0]          esum;
   logic                       accept, close;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign close     = req_last || (cnt_ff == CntW'(MAX_BLOCK - 1));
   assign push      = accept && close;

   always_comb begin
      prod     = ProdW'(cfg.two_cos) * ProdW'(d1_ff);
      prod_rnd = prod + ProdW'(14'sd4096 * 2);
      s0 = SumW'(req_sample) + SumW'(prod_rnd >>> 14) - SumW'(d2_ff);
      if (s0 > SatHi) begin
         d1_sat = ACC_BITS'(SatHi);
      end else if (s0 < SatLo) begin
         d1_sat = ACC_BITS'(SatLo);
      end else begin
         d1_sat = ACC_BITS'(s0);
      end

      sq   = 32'(req_sample) * 32'(req_sample);
      esum = (ENERGY_W+1)'(energy_ff) + (ENERGY_W+1)'($unsigned(sq));
      energy_sum = esum[ENERGY_W] ? '1 : esum[ENERGY_W-1:0];

      push_entry.d1     = DELAY_W'(d1_sat);
      push_entry.d2     = DELAY_W'(d1_ff);
      push_entry.energy = energy_sum;

      d1_in     = d1_ff;
      d2_in     = d2_ff;
      energy_in = energy_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         if (close) begin
            d1_in     = '0;
            d2_in     = '0;
            energy_in = '0;
            cnt_in    = '0;
         end else begin
            d1_in     = d1_sat;
            d2_in     = d1_ff;
            energy_in = energy_sum;
            cnt_in    = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff     <= '0;
         d2_ff     <= '0;
         energy_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         d1_ff     <= d1_in;
         d2_ff     <= d2_in;
         energy_ff <= energy_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/gtd_queue.sv =====
module gtd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  gtd_pkg::entry_type push_entry,
   output logic               q_full,
   output logic               q_valid,
   input  logic               pop,
   output gtd_pkg::entry_type head
);
   import gtd_pkg::*;

   entry_type  entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign q_full  = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2 || pop))
      else $error("queue push while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0)
      else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not follow push");
`endif

endmodule

// ===== hw/rtl/gtd_back.sv =====
module gtd_back (
   input  logic               clock,
   input  logic               reset,
   input  gtd_pkg::cfg_type   cfg,
   input  logic               q_valid,
   input  gtd_pkg::entry_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [39:0] rsp_real_part,
   output logic signed [39:0] rsp_imag_part,
   output logic [63:0]        rsp_bin_power,
   output logic               rsp_tone_found
);
   import gtd_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_ROUND, S_SQUARE, S_SUM, S_SCALE, S_ADD, S_CMP, S_OUT
   } state_type;

   function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
      if (v > 64'sd549755813887) begin
         return 40'sh7F_FFFF_FFFF;
      end else if (v < -64'sd549755813888) begin
         return 40'sh80_0000_0000;
      end else begin
         return v[39:0];
      end
   endfunction

   state_type                 state_ff;
   logic signed [DELAY_W-1:0] d1_ff, d2_ff;
   logic [ENERGY_W-1:0]       e_ff;
   logic signed [63:0]        pc_ff, ps_ff;
   logic signed [39:0]        re_ff, im_ff;
   logic [63:0]               pr_ff, pi_ff, power_ff;
   logic [47:0]               mh_ff;
   logic [63:0]               ml_ff;
   logic [79:0]               m_ff;
   logic                      rsp_valid_ff;

   logic signed [63:0] rc, rs, dr;
   logic [39:0]        mag_re, mag_im;
   logic [63:0]        sq_re, sq_im;
   logic [64:0]        psum;
   logic [47:0]        mh;
   logic [63:0]        ml;

   assign pop       = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      // round half up: add one half, then floor shift
      rc = (pc_ff + 64'sd8192) >>> 14;
      rs = (ps_ff + 64'sd8192) >>> 14;
      dr = 64'(d1_ff) - rc;

      mag_re = re_ff[39] ? $unsigned(-re_ff) : $unsigned(re_ff);
      mag_im = im_ff[39] ? $unsigned(-im_ff) : $unsigned(im_ff);
      sq_re  = (|mag_re[39:32]) ? '1 : mag_re[31:0] * mag_re[31:0];
      sq_im  = (|mag_im[39:32]) ? '1 : mag_im[31:0] * mag_im[31:0];

      psum = 65'(pr_ff) + 65'(pi_ff);

      mh = e_ff[47:32] * cfg.ratio;
      ml = e_ff[31:0] * cfg.ratio;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  d1_ff    <= head.d1;
                  d2_ff    <= head.d2;
                  e_ff     <= head.energy;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               pc_ff    <= 64'(d2_ff) * 64'(cfg.cos_q);
               ps_ff    <= 64'(d2_ff) * 64'(cfg.sin_q);
               state_ff <= S_ROUND;
            end
            S_ROUND: begin
               re_ff    <= sat40(dr);
               im_ff    <= sat40(rs);
               state_ff <= S_SQUARE;
            end
            S_SQUARE: begin
               pr_ff    <= sq_re;
               pi_ff    <= sq_im;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               power_ff <= psum[64] ? '1 : psum[63:0];
               state_ff <= S_SCALE;
            end
            S_SCALE: begin
               mh_ff    <= mh;
               ml_ff    <= ml;
               state_ff <= S_ADD;
            end
            S_ADD: begin
               m_ff     <= {mh_ff, 32'b0} + 80'(ml_ff);
               state_ff <= S_CMP;
            end
            S_CMP: begin
               rsp_real_part  <= re_ff;
               rsp_imag_part  <= im_ff;
               rsp_bin_power  <= power_ff;
               rsp_tone_found <= (e_ff != '0) && ({power_ff, 16'b0} > m_ff);
               rsp_valid_ff   <= 1'b1;
               state_ff       <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/goertzel_tone_detector.sv =====
// Single-bin Goertzel tone detector.
// Request channel (req_valid/req_ready): one signed 16-bit sample per request,
// req_last marks the final sample of a block; a block that reaches MAX_BLOCK
// samples closes on its own. Response channel (rsp_valid/rsp_ready): one
// response per block with real and imaginary parts, bin power and the detect
// flag. Coefficients and the threshold ratio are written through csr_we,
// csr_index and csr_wdata; the user must write them only while no block is in
// flight, which the block does not enforce. Throughput: one sample per cycle;
// requests stall only when the queue holds two finished blocks, i.e. when
// blocks close faster than the back stage drains them or the receiver stalls.
// The recurrence multiply-add is combinational in the front stage. A closed
// block goes to a two-entry queue; the back stage pops it when idle, runs
// multiply, round, square, sum, scale, add and compare, and pops the next
// block only after the response is taken. While rsp_ready is low the response
// holds and the front keeps taking samples until the queue fills.
// Reset clears the delays, energy and sample count, empties the queue and
// restores the register defaults (threshold ratio 1.0 in Q16.16).
module goertzel_tone_detector #(
   parameter int ACC_BITS  = 40,
   parameter int MAX_BLOCK = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [15:0]                  req_sample,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [39:0]                  rsp_real_part,
   output logic signed [39:0]                  rsp_imag_part,
   output logic [63:0]                         rsp_bin_power,
   output logic                                rsp_tone_found,
   input  logic                                csr_we,
   input  logic [gtd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gtd_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import gtd_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   entry_type push_entry, head;
   logic      push, pop, q_full, q_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_TWO_COS: cfg_in.two_cos = csr_wdata[16:0];
            REG_COS:     cfg_in.cos_q   = csr_wdata[15:0];
            REG_SIN:     cfg_in.sin_q   = csr_wdata[15:0];
            REG_RATIO:   cfg_in.ratio   = csr_wdata;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.two_cos <= '0;
         cfg_ff.cos_q   <= '0;
         cfg_ff.sin_q   <= '0;
         cfg_ff.ratio   <= RATIO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gtd_front #(
      .ACC_BITS  (ACC_BITS),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .req_last   (req_last),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   gtd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .pop        (pop),
      .head       (head)
   );

   gtd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_real_part  (rsp_real_part),
      .rsp_imag_part  (rsp_imag_part),
      .rsp_bin_power  (rsp_bin_power),
      .rsp_tone_found (rsp_tone_found)
   );

endmodule
